/* design/nfcrx_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nfcrx_pkg
// Shared types and constants of the NFC response frame receiver.
// ----------------------------------------------------------------------------
package nfcrx_pkg;

    localparam int MAX_BODY_BYTES = 22;
    localparam int BODY_IDX_W     = $clog2(MAX_BODY_BYTES);
    localparam int RESULT_W       = 154;
    localparam int OUT_TDATA_W    = 160;

    localparam logic [7:0] DIR_TO_HOST = 8'hD5;
    localparam logic [7:0] RESP_LEN_SHORT = 8'd18;
    localparam logic [7:0] RESP_LEN_LONG  = 8'd20;

    // configuration register indexes
    localparam logic [7:0] REG_SENT_CMD = 8'd0;
    localparam logic [7:0] REG_DECODE   = 8'd1;

    // status codes
    localparam logic [3:0] ST_CARD_OK    = 4'd0;
    localparam logic [3:0] ST_ACK_BAD    = 4'd1;
    localparam logic [3:0] ST_PREAMBLE   = 4'd2;
    localparam logic [3:0] ST_LEN_SUM    = 4'd3;
    localparam logic [3:0] ST_TOO_LONG   = 4'd4;
    localparam logic [3:0] ST_DIR_CMD    = 4'd5;
    localparam logic [3:0] ST_DATA_SUM   = 4'd6;
    localparam logic [3:0] ST_NO_CARD    = 4'd7;
    localparam logic [3:0] ST_TGT_COUNT  = 4'd8;
    localparam logic [3:0] ST_RESP_LEN   = 4'd9;
    localparam logic [3:0] ST_UNDECODED  = 4'd10;

    // one classified input beat
    typedef struct packed {
        logic       is_start;
        logic [7:0] data;
    } item_t;

    // one result, status in the lowest bits
    typedef struct packed {
        logic [4:0]  body_length;
        logic        sys_code_valid;
        logic [15:0] sys_code;
        logic [63:0] card_pmm;
        logic [63:0] card_idm;
        logic [3:0]  status;
    } result_t;

    function automatic logic [7:0] ack_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd2, 3'd4: b = 8'hFF;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

/* design/nfcrx_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nfcrx_front
// Accepts input beats, tags them as start or data and queues them (2 deep).
// ----------------------------------------------------------------------------
module nfcrx_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [7:0]      s_tdata,
    input  wire logic            s_tuser,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output nfcrx_pkg::item_t     q_item
);

    nfcrx_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // operation 0 opens a new exchange
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg].is_start <= ~s_tuser;
            slot_reg[wr_ptr_reg].data     <= s_tdata;
        end
    end

endmodule
`default_nettype wire

/* design/nfcrx_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nfcrx_back
// Frame parser: walks ACK, preamble, LEN/LCS, direction, body and tail,
// holds the body bytes and the config registers, registers one result.
// ----------------------------------------------------------------------------
module nfcrx_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire nfcrx_pkg::item_t q_item,
    input  wire logic             cfg_valid,
    input  wire logic [7:0]       cfg_index,
    input  wire logic [7:0]       cfg_data,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output nfcrx_pkg::result_t    res_data
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ACK  = 3'd1;
    localparam logic [2:0] PH_PRE  = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_DIR  = 3'd4;
    localparam logic [2:0] PH_BODY = 3'd5;
    localparam logic [2:0] PH_TAIL = 3'd6;

    localparam int IW = nfcrx_pkg::BODY_IDX_W;

    logic [2:0]    phase_reg, phase_next;
    logic [IW-1:0] count_reg, count_next;
    logic [7:0]    flen_reg, flen_next;
    logic [IW-1:0] bexp_reg, bexp_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    cmd_reg;
    logic          decode_reg;
    logic [7:0]    body_reg [nfcrx_pkg::MAX_BODY_BYTES];
    logic          out_valid_reg, out_valid_next;
    nfcrx_pkg::result_t out_reg;

    logic          take;
    logic          store_clr, store_we;
    logic          fin;
    logic [3:0]    fin_status;
    logic [7:0]    b, reply, blen8;
    logic          mis;
    nfcrx_pkg::result_t res_next;

    assign take      = q_valid && (!out_valid_reg || res_ready);
    assign q_ready   = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;
    assign b         = q_item.data;
    assign reply     = cmd_reg + 8'd1;
    assign blen8     = flen_reg - 8'd2;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        flen_next  = flen_reg;
        bexp_next  = bexp_reg;
        sum_next   = sum_reg;
        store_clr  = 1'b0;
        store_we   = 1'b0;
        fin        = 1'b0;
        fin_status = nfcrx_pkg::ST_CARD_OK;
        mis        = 1'b0;
        if (take) begin
            if (q_item.is_start) begin
                phase_next = PH_ACK;
                count_next = '0;
                flen_next  = '0;
                bexp_next  = '0;
                sum_next   = '0;
                store_clr  = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_ACK: begin
                        mis        = (b != nfcrx_pkg::ack_byte(count_reg[2:0]));
                        sum_next   = mis ? 8'd1 : sum_reg;
                        count_next = count_reg + 1'b1;
                        if (count_reg == IW'(5)) begin
                            count_next = '0;
                            if (mis || sum_reg != 8'd0) begin
                                fin        = 1'b1;
                                fin_status = nfcrx_pkg::ST_ACK_BAD;
                            end else begin
                                phase_next = PH_PRE;
                            end
                        end
                    end
                    PH_PRE: begin
                        if (count_reg < IW'(2)) mis = (b != 8'h00);
                        else                    mis = (b != 8'hFF) && (b != 8'h00);
                        sum_next   = mis ? 8'd1 : sum_reg;
                        count_next = count_reg + 1'b1;
                        if (count_reg == IW'(2)) begin
                            count_next = '0;
                            if (mis || sum_reg != 8'd0) begin
                                fin        = 1'b1;
                                fin_status = nfcrx_pkg::ST_PREAMBLE;
                            end else begin
                                phase_next = PH_LEN;
                            end
                        end
                    end
                    PH_LEN: begin
                        if (count_reg == '0) begin
                            flen_next  = b;
                            count_next = IW'(1);
                        end else if (flen_reg + b != 8'd0) begin
                            fin        = 1'b1;
                            fin_status = nfcrx_pkg::ST_LEN_SUM;
                        end else if (blen8 > 8'(nfcrx_pkg::MAX_BODY_BYTES)) begin
                            fin        = 1'b1;
                            fin_status = nfcrx_pkg::ST_TOO_LONG;
                        end else begin
                            bexp_next  = blen8[IW-1:0];
                            phase_next = PH_DIR;
                            count_next = '0;
                            sum_next   = '0;
                        end
                    end
                    PH_DIR: begin
                        if (count_reg == '0) begin
                            if (b != nfcrx_pkg::DIR_TO_HOST) sum_next = 8'd1;
                            count_next = IW'(1);
                        end else if (sum_reg != 8'd0 || b != reply) begin
                            fin        = 1'b1;
                            fin_status = nfcrx_pkg::ST_DIR_CMD;
                        end else begin
                            // seed the body checksum with TFI and command
                            sum_next   = nfcrx_pkg::DIR_TO_HOST + reply;
                            count_next = '0;
                            phase_next = (bexp_reg == '0) ? PH_TAIL : PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        store_we   = 1'b1;
                        sum_next   = sum_reg + b;
                        count_next = count_reg + 1'b1;
                        if (count_reg + 1'b1 >= bexp_reg) begin
                            phase_next = PH_TAIL;
                            count_next = '0;
                        end
                    end
                    PH_TAIL: begin
                        if (count_reg == '0) begin
                            sum_next   = sum_reg + b;
                            count_next = IW'(1);
                        end else begin
                            fin = 1'b1;
                            priority if (sum_reg != 8'd0 || b != 8'h00)
                                fin_status = nfcrx_pkg::ST_DATA_SUM;
                            else if (!decode_reg)
                                fin_status = nfcrx_pkg::ST_UNDECODED;
                            else if (body_reg[0] == 8'd0)
                                fin_status = nfcrx_pkg::ST_NO_CARD;
                            else if (body_reg[0] != 8'd1)
                                fin_status = nfcrx_pkg::ST_TGT_COUNT;
                            else if (body_reg[2] != nfcrx_pkg::RESP_LEN_SHORT &&
                                     body_reg[2] != nfcrx_pkg::RESP_LEN_LONG)
                                fin_status = nfcrx_pkg::ST_RESP_LEN;
                            else
                                fin_status = nfcrx_pkg::ST_CARD_OK;
                        end
                    end
                    default: begin
                        // idle: drop the byte
                    end
                endcase
                if (fin) phase_next = PH_IDLE;
            end
        end
    end

    // assemble the result from the fixed body slots
    always_comb begin
        res_next             = '0;
        res_next.status      = fin_status;
        res_next.body_length = bexp_reg;
        if (fin_status == nfcrx_pkg::ST_CARD_OK) begin
            for (int k = 0; k < 8; k++) begin
                res_next.card_idm[63-8*k -: 8] = body_reg[4+k];
                res_next.card_pmm[63-8*k -: 8] = body_reg[12+k];
            end
            if (body_reg[2] == nfcrx_pkg::RESP_LEN_LONG) begin
                res_next.sys_code       = {body_reg[20], body_reg[21]};
                res_next.sys_code_valid = 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fin)            out_valid_next = 1'b1;
        else if (res_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            flen_reg      <= '0;
            bexp_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= 8'd74;
            decode_reg    <= 1'b1;
        end else begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            flen_reg      <= flen_next;
            bexp_reg      <= bexp_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                if (cfg_index == nfcrx_pkg::REG_SENT_CMD) cmd_reg    <= cfg_data;
                if (cfg_index == nfcrx_pkg::REG_DECODE)   decode_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin) out_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (store_clr) begin
            for (int k = 0; k < nfcrx_pkg::MAX_BODY_BYTES; k++) body_reg[k] <= 8'h00;
        end else if (store_we) begin
            body_reg[count_reg] <= b;
        end
    end

endmodule
`default_nettype wire

/* design/nfc_response_frame_receiver_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_response_frame_receiver_core
// Checks NFC controller response frames received over UART, one byte a beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per UART byte. s_tuser is the operation: 0 arms a
//   new exchange (ACK expected next), 1 carries a received byte in s_tdata.
//   m_ channel: one beat per finished frame or first error, carrying the
//   status and, for a decoded card, IDm, PMm and the optional system code.
//   cfg channel: index 0 sent command code, index 1 decode enable; always
//   ready, write only while the block is idle.
// Throughput: one input beat per cycle while the result is not held, set by the
// byte-wide checksum and counter of the parser. A 2-entry queue sits between the
// input side and the parser.
// Result path: the beat that ends the frame is registered in the queue, then the
// parser takes it and registers the result and m_tvalid.
// Reset: parser goes idle and drops bytes until a start beat; config
// registers return to command 74 and decode on. When m_tready is low the
// result holds, the parser stalls and the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module nfc_response_frame_receiver_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,     // [7:0] rx_byte
    input  wire logic         s_tuser,     // [0] operation
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [3:0] status, [67:4] card_idm, [131:68] card_pmm, [147:132] sys_code,
    // [148] sys_code_valid, [153:149] body_length, [159:154] zero
    output logic [159:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [7:0]   cfg_data
);

    logic               q_valid, q_ready;
    nfcrx_pkg::item_t   q_item;
    nfcrx_pkg::result_t res_data;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {(nfcrx_pkg::OUT_TDATA_W - nfcrx_pkg::RESULT_W)'(0), res_data};

    nfcrx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    nfcrx_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res_data)
    );

endmodule
`default_nettype wire

/* tb/nfc_response_frame_receiver_core_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_response_frame_receiver_core_test
// Feeds start beats and UART response bytes into the frame receiver: a short
// directed set of good and broken frames, then random exchanges under several
// command codes and decode settings. A byte-level parser model predicts each
// status beat, which is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module nfc_response_frame_receiver_core_test;
    import nfcrx_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 25;
    localparam int PHASE_BEATS    = 28;
    localparam int REPORT_LIMIT   = 10;

    // ACK frame 00 00 FF 00 FF 00, first byte in the lowest bits
    localparam logic [47:0] ACK_FRAME = 48'h00FF_00FF_0000;

    typedef enum logic [2:0] {
        PH_IDLE, PH_ACK, PH_PRE, PH_LEN, PH_DIR, PH_BODY, PH_TAIL
    } parse_phase_e;

    typedef enum int {
        F_NONE, F_ACK, F_PRE, F_LCS, F_LEN_WRAP, F_LONG, F_DIR, F_CMD, F_DCS,
        F_POST, F_NO_CARD, F_TGT, F_RESP_LEN, F_ABANDON, F_TRAILING
    } flaw_e;

    class frame_status_model;
        logic [7:0]   sent_cmd;
        bit           decode_on;
        parse_phase_e phase;
        int unsigned  count;
        logic [7:0]   len_byte;
        logic [7:0]   body_len;
        logic [7:0]   sum;
        logic [7:0]   body [MAX_BODY_BYTES];
        result_t      due_status [$];
        int unsigned  faults;
        int unsigned  matched;

        function new();
            sent_cmd  = 8'd74;
            decode_on = 1'b1;
            faults    = 0;
            matched   = 0;
            clear_frame();
            phase     = PH_IDLE;
        endfunction

        function void clear_frame();
            count    = 0;
            len_byte = 8'd0;
            body_len = 8'd0;
            sum      = 8'd0;
            foreach (body[i]) body[i] = 8'd0;
        endfunction

        function void set_reg(input logic [7:0] idx, input logic [7:0] val);
            if (idx == REG_SENT_CMD)
                sent_cmd = val;
            else if (idx == REG_DECODE)
                decode_on = val[0];
        endfunction

        function void conclude(input logic [3:0] st, input bit with_len);
            result_t r;
            r = '0;
            r.status = st;
            r.body_length = with_len ? body_len[4:0] : 5'd0;
            if (st == ST_CARD_OK) begin
                for (int k = 0; k < 8; k++) begin
                    r.card_idm = {r.card_idm[55:0], body[4 + k]};
                    r.card_pmm = {r.card_pmm[55:0], body[12 + k]};
                end
                if (body[2] == RESP_LEN_LONG) begin
                    r.sys_code = {body[20], body[21]};
                    r.sys_code_valid = 1'b1;
                end
            end
            due_status.push_back(r);
            phase = PH_IDLE;
        endfunction

        function void take_beat(input bit op, input logic [7:0] b);
            logic [7:0] reply;
            logic [7:0] t;
            reply = sent_cmd + 8'd1;
            if (!op) begin
                clear_frame();
                phase = PH_ACK;
                return;
            end
            case (phase)
                PH_ACK: begin
                    if (b != ACK_FRAME[8 * count +: 8])
                        sum = 8'd1;
                    count++;
                    if (count == 6) begin
                        if (sum != 8'd0) begin
                            conclude(ST_ACK_BAD, 1'b0);
                        end else begin
                            phase = PH_PRE;
                            count = 0;
                        end
                    end
                end
                PH_PRE: begin
                    if (count < 2) begin
                        if (b != 8'h00)
                            sum = 8'd1;
                    end else if (b != 8'hFF && b != 8'h00) begin
                        sum = 8'd1;
                    end
                    count++;
                    if (count == 3) begin
                        if (sum != 8'd0) begin
                            conclude(ST_PREAMBLE, 1'b0);
                        end else begin
                            phase = PH_LEN;
                            count = 0;
                        end
                    end
                end
                PH_LEN: begin
                    t = len_byte + b;
                    if (count == 0) begin
                        len_byte = b;
                        count = 1;
                    end else if (t != 8'd0) begin
                        conclude(ST_LEN_SUM, 1'b0);
                    end else if (8'(len_byte - 8'd2) > MAX_BODY_BYTES) begin
                        // LEN below two wraps here as well
                        conclude(ST_TOO_LONG, 1'b0);
                    end else begin
                        body_len = len_byte - 8'd2;
                        phase = PH_DIR;
                        count = 0;
                        sum = 8'd0;
                    end
                end
                PH_DIR: begin
                    if (count == 0) begin
                        if (b != DIR_TO_HOST)
                            sum = 8'd1;
                        count = 1;
                    end else if (sum != 8'd0 || b != reply) begin
                        conclude(ST_DIR_CMD, 1'b1);
                    end else begin
                        sum = DIR_TO_HOST + reply;
                        count = 0;
                        phase = (body_len == 8'd0) ? PH_TAIL : PH_BODY;
                    end
                end
                PH_BODY: begin
                    body[count] = b;
                    sum = sum + b;
                    count++;
                    if (count >= body_len) begin
                        phase = PH_TAIL;
                        count = 0;
                    end
                end
                PH_TAIL: begin
                    if (count == 0) begin
                        sum = sum + b;
                        count = 1;
                    end else if (sum != 8'd0 || b != 8'h00) begin
                        conclude(ST_DATA_SUM, 1'b1);
                    end else if (!decode_on) begin
                        conclude(ST_UNDECODED, 1'b1);
                    end else if (body[0] == 8'd0) begin
                        conclude(ST_NO_CARD, 1'b1);
                    end else if (body[0] != 8'd1) begin
                        conclude(ST_TGT_COUNT, 1'b1);
                    end else if (body[2] != RESP_LEN_SHORT && body[2] != RESP_LEN_LONG) begin
                        conclude(ST_RESP_LEN, 1'b1);
                    end else begin
                        conclude(ST_CARD_OK, 1'b1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void match_status(input result_t got);
            result_t want;
            matched++;
            if (due_status.size() == 0) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("status beat %0d arrived with none due: status %0d",
                             matched, got.status);
                return;
            end
            want = due_status.pop_front();
            if (got.status !== want.status || got.card_idm !== want.card_idm ||
                got.card_pmm !== want.card_pmm || got.sys_code !== want.sys_code ||
                got.sys_code_valid !== want.sys_code_valid ||
                got.body_length !== want.body_length) begin
                faults++;
                if (faults <= REPORT_LIMIT) begin
                    $display("status beat %0d expected: st %0d idm %h pmm %h sc %h/%b len %0d",
                             matched, want.status, want.card_idm, want.card_pmm,
                             want.sys_code, want.sys_code_valid, want.body_length);
                    $display("status beat %0d actual:   st %0d idm %h pmm %h sc %h/%b len %0d",
                             matched, got.status, got.card_idm, got.card_pmm,
                             got.sys_code, got.sys_code_valid, got.body_length);
                end
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [7:0]   cfg_data;

    frame_status_model sb;
    logic [7:0]        frame_bytes [$];
    int unsigned       beats_sent = 0;
    int unsigned       results_seen = 0;
    int unsigned       idle_cycles = 0;
    bit                sender_steady = 1'b0;

    nfc_response_frame_receiver_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Build the byte sequence of one controller response, ACK first.
    function automatic void build_frame(input flaw_e flaw, input int unsigned n,
                                        input bit shaped);
        logic [7:0]  body [$];
        logic [7:0]  pre [3];
        logic [47:0] ack;
        logic [7:0]  len, lcs, dir, reply, dcs, post, v;
        int unsigned pos;
        frame_bytes.delete();
        if (flaw == F_NO_CARD || flaw == F_TGT || flaw == F_RESP_LEN) begin
            if (n < 3)
                n = 3;
            shaped = 1'b1;
        end
        repeat (n) body.push_back(8'($urandom_range(0, 255)));
        if (shaped && n >= 3) begin
            body[0] = 8'd1;
            body[2] = (n >= MAX_BODY_BYTES) ? RESP_LEN_LONG : RESP_LEN_SHORT;
            if ($urandom_range(0, 4) == 0)
                body[2] = (body[2] == RESP_LEN_LONG) ? RESP_LEN_SHORT : RESP_LEN_LONG;
            body[3] = 8'h01;
        end
        case (flaw)
            F_NO_CARD: body[0] = 8'd0;
            F_TGT:     body[0] = 8'($urandom_range(2, 255));
            F_RESP_LEN: begin
                do v = 8'($urandom_range(0, 255));
                while (v == RESP_LEN_SHORT || v == RESP_LEN_LONG);
                body[2] = v;
            end
            default: ;
        endcase

        ack = ACK_FRAME;
        if (flaw == F_ACK) begin
            pos = $urandom_range(0, 5);
            ack[8 * pos +: 8] = ack[8 * pos +: 8] ^ 8'($urandom_range(1, 255));
        end
        pre[0] = 8'h00;
        pre[1] = 8'h00;
        pre[2] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if (flaw == F_PRE) begin
            pos = $urandom_range(0, 2);
            pre[pos] = (pos < 2) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 254));
        end
        len = 8'(n + 2);
        if (flaw == F_LEN_WRAP)
            len = 8'($urandom_range(0, 1));
        if (flaw == F_LONG)
            len = 8'($urandom_range(MAX_BODY_BYTES + 3, 255));
        lcs = 8'd0 - len;
        if (flaw == F_LCS)
            lcs = lcs ^ 8'($urandom_range(1, 255));
        dir = DIR_TO_HOST;
        reply = sb.sent_cmd + 8'd1;
        dcs = 8'd0 - (dir + reply);
        foreach (body[i]) dcs = dcs - body[i];
        if (flaw == F_DIR)
            dir = dir ^ 8'($urandom_range(1, 255));
        if (flaw == F_CMD)
            reply = reply ^ 8'($urandom_range(1, 255));
        if (flaw == F_DCS)
            dcs = dcs ^ 8'($urandom_range(1, 255));
        post = (flaw == F_POST) ? 8'($urandom_range(1, 255)) : 8'h00;

        for (int i = 0; i < 6; i++) frame_bytes.push_back(ack[8 * i +: 8]);
        foreach (pre[i]) frame_bytes.push_back(pre[i]);
        frame_bytes.push_back(len);
        frame_bytes.push_back(lcs);
        frame_bytes.push_back(dir);
        frame_bytes.push_back(reply);
        foreach (body[i]) frame_bytes.push_back(body[i]);
        frame_bytes.push_back(dcs);
        frame_bytes.push_back(post);

        if (flaw == F_ABANDON) begin
            // cut before the postamble so that the next start drops the frame
            pos = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > pos) void'(frame_bytes.pop_back());
        end
        if (flaw == F_TRAILING)
            repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_beat(input bit op, input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap(sender_steady);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.take_beat(op, b);
        beats_sent++;
    endtask

    task automatic send_exchange(input flaw_e flaw, input int unsigned n, input bit shaped);
        sender_steady = ($urandom_range(0, 3) == 0);
        build_frame(flaw, n, shaped);
        send_beat(1'b0, 8'($urandom_range(0, 255)));
        foreach (frame_bytes[i]) send_beat(1'b1, frame_bytes[i]);
    endtask

    task automatic random_exchange();
        flaw_e       flaw;
        int unsigned n;
        if ($urandom_range(0, 99) < 45)
            flaw = F_NONE;
        else
            flaw = flaw_e'($urandom_range(1, F_TRAILING));
        if ($urandom_range(0, 9) < 6)
            n = $urandom_range(0, 1) ? 20 : MAX_BODY_BYTES;
        else
            n = $urandom_range(0, MAX_BODY_BYTES);
        send_exchange(flaw, n, $urandom_range(0, 4) != 0);
    endtask

    // Drop valid, drain all due status beats, then let the pipeline empty.
    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.due_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_setting(input logic [7:0] cmd, input bit decode);
        int unsigned stop_at;
        write_reg(REG_SENT_CMD, cmd);
        write_reg(REG_DECODE, {7'd0, decode});
        stop_at = beats_sent + PHASE_BEATS;
        while (beats_sent < stop_at) random_exchange();
        // close on a complete frame so the parser is idle for the next write
        send_exchange(F_NONE, 20, 1'b1);
        wait_quiet();
    endtask

    // result side: random stalls and one long hold-off
    initial begin
        int unsigned gap;
        bit          held_off;
        held_off = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (results_seen == HOLD_AT_RESULT && !held_off) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                gap = pick_gap($urandom_range(0, 5) == 0);
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.match_status(result_t'(m_tdata[RESULT_W-1:0]));
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** nfc_response_frame_receiver_core: FAILED **");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = 8'd0;
        cfg_data  = 8'd0;
        sb = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // bytes before any start are dropped
        send_beat(1'b1, 8'h00);
        send_beat(1'b1, 8'hFF);
        send_exchange(F_NONE, 20, 1'b1);
        send_exchange(F_NONE, MAX_BODY_BYTES, 1'b1);
        send_exchange(F_ACK, 0, 1'b0);
        send_exchange(F_PRE, 0, 1'b0);
        send_exchange(F_LCS, 2, 1'b0);
        send_exchange(F_LEN_WRAP, 0, 1'b0);
        send_exchange(F_LONG, 0, 1'b0);
        send_exchange(F_DIR, 1, 1'b0);
        send_exchange(F_CMD, 1, 1'b0);
        send_exchange(F_DCS, 4, 1'b0);
        send_exchange(F_POST, 4, 1'b0);
        send_exchange(F_NONE, 0, 1'b0);
        send_exchange(F_NONE, 3, 1'b1);
        send_exchange(F_TGT, 3, 1'b1);
        send_exchange(F_RESP_LEN, 4, 1'b1);
        send_exchange(F_ABANDON, 20, 1'b1);
        send_exchange(F_TRAILING, 5, 1'b1);
        send_exchange(F_NO_CARD, 3, 1'b1);
        wait_quiet();

        run_setting(8'd0, 1'b1);
        run_setting(8'd254, 1'b0);
        run_setting(8'($urandom_range(1, 253)), 1'b1);
        run_setting(8'd254, 1'b1);
        run_setting(8'd0, 1'b0);
        run_setting(8'($urandom_range(0, 254)), 1'($urandom_range(0, 1)));

        if (sb.faults == 0)
            $display("** nfc_response_frame_receiver_core: PASSED **");
        else
            $display("** nfc_response_frame_receiver_core: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
